// ===== rtl/mean_centered_vector_quantizer_defines.svh =====
// Assertion helpers for the checker file.
`ifndef MEAN_CENTERED_VECTOR_QUANTIZER_DEFINES_SVH
`define MEAN_CENTERED_VECTOR_QUANTIZER_DEFINES_SVH

// Check that holds out of reset.
`define MCVQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcvq: check failed");

// Check in the cycle after the antecedent, reset included.
`define MCVQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mcvq: check failed");

`endif

// ===== rtl/mcvq_pkg.sv =====
`default_nettype none
package mcvq_pkg;
    localparam int MAX_SAMPLES_DEF = 32;
    localparam int DATA_W  = 16;
    localparam int OFF_W   = 10;
    localparam int MEAN_W  = 24;
    localparam int STEP_W  = 16;
    // count, sum and divider widths cover the full capacity range up to 63
    localparam int CNT_W   = 6;
    localparam int SUM_W   = DATA_W + CNT_W;
    localparam int PROD_W  = SUM_W + 2;
    localparam int NUM_W   = 25 + CNT_W;
    localparam int NUMS_W  = NUM_W + 2;
    localparam int DEN_W   = DATA_W + CNT_W;
    localparam int STEP_DIV = 510;
    localparam int Q_SHIFT  = 8;

    typedef struct packed {
        logic                     en;
        logic [CNT_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic signed [DATA_W-1:0] min;
        logic signed [DATA_W-1:0] max;
        logic [CNT_W-1:0]         cnt;
        logic                     drop;
    } t_job;

    typedef struct packed {
        logic signed [OFF_W-1:0]  offset;
        logic signed [MEAN_W-1:0] mean_value;
        logic [STEP_W-1:0]        step_size;
        logic                     end_of_vector;
        logic                     overflowed;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/mcvq_queue.sv =====
`default_nettype none
module mcvq_queue #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output T     o_data
);
    T           r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mcvq_front.sv =====
`default_nettype none
module mcvq_front #(
    parameter int MAX_SAMPLES = mcvq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [mcvq_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_last,
    input  logic                              i_job_empty,
    input  logic                              i_busy,
    output mcvq_pkg::t_wr                     o_wr,
    output logic                              o_job_push,
    output mcvq_pkg::t_job                    o_job
);
    import mcvq_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_SAMPLES);
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic signed [DATA_W-1:0] r_max, n_max;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_drop, n_drop;
    logic                     acc;
    logic                     keep;

    // hold new samples while a vector waits or is being emitted
    assign full = ~i_job_empty | i_busy;
    assign acc  = push & ~full;
    assign keep = (r_cnt < CAP);

    always_comb begin
        n_sum  = r_sum;
        n_min  = r_min;
        n_max  = r_max;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        if (keep) begin
            n_sum = r_sum + SUM_W'(i_sample);
            n_cnt = r_cnt + 1'b1;
            if (i_sample < r_min) n_min = i_sample;
            if (i_sample > r_max) n_max = i_sample;
        end else begin
            n_drop = 1'b1;
        end
    end

    assign o_wr.en    = acc & keep;
    assign o_wr.addr  = r_cnt;
    assign o_wr.data  = i_sample;
    assign o_job_push = acc & i_last;
    assign o_job.sum  = n_sum;
    assign o_job.min  = n_min;
    assign o_job.max  = n_max;
    assign o_job.cnt  = n_cnt;
    assign o_job.drop = n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_last)) begin
            r_sum  <= '0;
            r_min  <= MOST_POS;
            r_max  <= MOST_NEG;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else if (acc) begin
            r_sum  <= n_sum;
            r_min  <= n_min;
            r_max  <= n_max;
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mcvq_div.sv =====
`default_nettype none
module mcvq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mcvq_pkg::NUM_W-1:0]   i_num,
    input  logic [mcvq_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [mcvq_pkg::NUM_W-1:0]   o_quo
);
    import mcvq_pkg::*;

    localparam int IW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [IW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    logic             borrow;

    assign sh     = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign diff   = {1'b0, sh} - {2'b00, r_den};
    assign borrow = diff[DEN_W+1];
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= IW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ~borrow};
            r_rem <= borrow ? sh : diff[DEN_W:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mcvq_back.sv =====
`default_nettype none
module mcvq_back #(
    parameter int MAX_SAMPLES = mcvq_pkg::MAX_SAMPLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mcvq_pkg::t_wr  i_wr,
    input  logic           i_job_empty,
    input  mcvq_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_busy,
    input  logic           i_res_full,
    output logic           o_res_push,
    output mcvq_pkg::t_res o_res
);
    import mcvq_pkg::*;

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic signed [NUMS_W-1:0] K_SCALE = NUMS_W'(STEP_DIV);
    // range*256/510 = (range*128)/255, taken as (range*128)*ceil(2^31/255) >> 31
    localparam int STEP_SH = 31;
    localparam logic [23:0] STEP_RECIP = 24'd8421505;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_MEAN_W, S_STEP,
        S_RD, S_PROD, S_SCALE, S_OFF, S_OFF_W, S_OUT
    } t_state;

    logic signed [DATA_W-1:0] r_store [MAX_SAMPLES];

    t_state                   r_state;
    logic [CNT_W-1:0]         r_n;
    logic signed [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0]        r_range;
    logic                     r_drop;
    logic signed [MEAN_W-1:0] r_mean;
    logic [STEP_W-1:0]        r_step;
    logic [DEN_W-1:0]         r_den;
    logic [CNT_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUMS_W-1:0] r_num;
    logic signed [OFF_W-1:0]  r_off;

    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         div_q;
    logic [NUM_W-1:0]         q_neg;
    logic [SUM_W-1:0]         sum_mag;
    logic [NUMS_W-1:0]        num_mag;
    logic signed [PROD_W-1:0] nv;
    logic [DATA_W:0]          diff;
    logic                     at_end;
    logic [47:0]              step_prod;

    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign num_mag   = r_num[NUMS_W-1] ? NUMS_W'(-r_num) : NUMS_W'(r_num);
    assign q_neg     = NUM_W'(-div_q);
    assign nv        = $signed({1'b0, r_n}) * r_v;
    assign diff      = {i_job.max[DATA_W-1], i_job.max} - {i_job.min[DATA_W-1], i_job.min};
    assign at_end    = (r_idx == r_n - 1'b1);
    assign step_prod = {r_range, 7'b0} * STEP_RECIP;

    always_comb begin
        div_start = 1'b0;
        div_num   = num_mag[NUM_W-1:0];
        div_den   = r_den;
        unique case (r_state)
            S_MEAN: begin
                div_start = 1'b1;
                div_num   = NUM_W'(sum_mag) << Q_SHIFT;
                div_den   = DEN_W'(r_n);
            end
            S_OFF: begin
                div_start = (r_range != '0);
            end
            default: begin
            end
        endcase
    end

    mcvq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_n     <= i_job.cnt;
                        r_sum   <= i_job.sum;
                        r_range <= diff[DATA_W-1:0];
                        r_drop  <= i_job.drop;
                        r_idx   <= '0;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: r_state <= S_MEAN_W;
                S_MEAN_W: begin
                    if (div_done) begin
                        r_mean  <= r_sum[SUM_W-1] ? q_neg[MEAN_W-1:0] : div_q[MEAN_W-1:0];
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_step  <= step_prod[STEP_SH +: STEP_W];
                    r_den   <= DEN_W'(r_n) * DEN_W'(r_range);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_v     <= r_store[r_idx[AW-1:0]];
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_prod  <= nv - PROD_W'(r_sum);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_num   <= NUMS_W'(r_prod) * K_SCALE;
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    // equal samples: offset is zero, skip the divide
                    if (r_range == '0) begin
                        r_off   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_OFF_W;
                    end
                end
                S_OFF_W: begin
                    if (div_done) begin
                        r_off   <= r_num[NUMS_W-1] ? q_neg[OFF_W-1:0] : div_q[OFF_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        if (at_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_job_pop  = (r_state == S_IDLE) & ~i_job_empty;
    assign o_busy     = (r_state != S_IDLE);
    assign o_res_push = (r_state == S_OUT) & ~i_res_full;

    assign o_res.offset        = r_off;
    assign o_res.mean_value    = r_mean;
    assign o_res.step_size     = r_step;
    assign o_res.end_of_vector = at_end;
    assign o_res.overflowed    = r_drop;
endmodule
`default_nettype wire

// ===== rtl/mean_centered_vector_quantizer.sv =====
// Mean-centered vector quantizer.
// Input queue: drive i_sample/i_last with push; a beat is taken when push is
// high and full is low. i_last closes the vector. Samples past MAX_SAMPLES are
// dropped and flag overflowed on every result of that vector.
// Result queue: while empty is low the oldest result sits on the o_ ports;
// pop takes it. One result per stored sample, in arrival order.
// Each sample beat is taken in the cycle it is offered with full low. After the last beat, full stays high
// until the whole vector has been emitted.
// After the last beat, the first result follows the mean divide and then the first
// offset divide (skipped when all samples are equal); each further result waits
// on one more offset divide. Both run on the shared bit-serial divider that
// retires one quotient bit per cycle.
// A two-entry result queue absorbs pop stalls; once it fills, the emitter
// waits and no result is lost.
// Reset (synchronous, active low) empties both queues, clears the running
// sum, minimum, maximum and count, and returns the emitter to idle.
`default_nettype none
module mean_centered_vector_quantizer #(
    parameter int MAX_SAMPLES = mcvq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [mcvq_pkg::DATA_W-1:0] i_sample,
    input  logic                               i_last,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [mcvq_pkg::OFF_W-1:0]  o_offset,
    output logic signed [mcvq_pkg::MEAN_W-1:0] o_mean_value,
    output logic [mcvq_pkg::STEP_W-1:0]        o_step_size,
    output logic                               o_end_of_vector,
    output logic                               o_overflowed
);
    import mcvq_pkg::*;

    t_wr  wr;
    t_job job_in, job_out;
    t_res res_in, res_out;
    logic job_push, job_pop, job_empty, job_full;
    logic res_push, res_full;
    logic busy;

    mcvq_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_job_empty (job_empty),
        .i_busy      (busy),
        .o_wr        (wr),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    mcvq_queue #(.T(t_job)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .o_empty (job_empty),
        .i_pop   (job_pop),
        .o_data  (job_out)
    );

    mcvq_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_busy      (busy),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    mcvq_queue #(.T(t_res)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (res_out)
    );

    assign o_offset        = res_out.offset;
    assign o_mean_value    = res_out.mean_value;
    assign o_step_size     = res_out.step_size;
    assign o_end_of_vector = res_out.end_of_vector;
    // job queue never fills: the front holds while one vector is pending
    assign o_overflowed    = res_out.overflowed & ~job_full;
endmodule
`default_nettype wire

// ===== rtl/mcvq_checker.sv =====
`default_nettype none
`include "mean_centered_vector_quantizer_defines.svh"
module mcvq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               push,
    input logic                               full,
    input logic signed [mcvq_pkg::DATA_W-1:0] i_sample,
    input logic                               i_last,
    input logic                               empty,
    input logic                               pop,
    input logic signed [mcvq_pkg::OFF_W-1:0]  o_offset,
    input logic signed [mcvq_pkg::MEAN_W-1:0] o_mean_value,
    input logic [mcvq_pkg::STEP_W-1:0]        o_step_size,
    input logic                               o_end_of_vector,
    input logic                               o_overflowed
);
    `MCVQ_ASSERT_NXT(a_rst_empty, !i_rst_n, empty)
    `MCVQ_ASSERT_NXT(a_rst_ready, !i_rst_n, !full)
    `MCVQ_ASSERT_IMP(a_off_range, !empty, (o_offset <= 10'sd510) && (o_offset >= -10'sd510))
    `MCVQ_ASSERT_IMP(a_stall_hold, ##1 ($past(!empty && !pop) && !empty), $stable(o_offset) && $stable(o_mean_value) && $stable(o_step_size) && $stable(o_end_of_vector))
endmodule

bind mean_centered_vector_quantizer mcvq_checker u_mcvq_checker (.*);
`default_nettype wire

// ===== verif/mcvq_result_checker.sv =====
`default_nettype none
module mcvq_result_checker
    import mcvq_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    input  logic                     full,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_last,
    input  logic                     empty,
    input  logic                     pop,
    input  logic signed [OFF_W-1:0]  o_offset,
    input  logic signed [MEAN_W-1:0] o_mean_value,
    input  logic [STEP_W-1:0]        o_step_size,
    input  logic                     o_end_of_vector,
    input  logic                     o_overflowed,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_vectors,
    output int                       o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    t_res                    quant_queue[$];
    logic signed [DATA_W-1:0] vec_samples[MAX_SAMPLES];
    longint                  vec_sum;
    longint                  vec_min;
    longint                  vec_max;
    int                      vec_cnt;
    logic                    vec_drop;

    task automatic clear_vector();
        vec_sum  = 0;
        vec_min  = 32767;
        vec_max  = -32768;
        vec_cnt  = 0;
        vec_drop = 1'b0;
    endtask

    // Queue one expected result per stored sample of the closed vector.
    task automatic quantize_vector();
        longint n, range, mean, step, off;
        t_res   r;
        n     = vec_cnt;
        range = vec_max - vec_min;
        if (range < 0) range = 0;
        mean  = (vec_sum * 256) / n;
        step  = (range * 256) / STEP_DIV;
        for (int k = 0; k < vec_cnt; k++) begin
            off = 0;
            if (range > 0)
                off = ((n * longint'(vec_samples[k]) - vec_sum) * 510) / (n * range);
            r.offset        = off[OFF_W-1:0];
            r.mean_value    = mean[MEAN_W-1:0];
            r.step_size     = step[STEP_W-1:0];
            r.end_of_vector = (k + 1 == vec_cnt);
            r.overflowed    = vec_drop;
            quant_queue.push_back(r);
        end
        o_vectors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_vectors = 0;
        o_results = 0;
        clear_vector();
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (push && !full) begin
                if (vec_cnt < MAX_SAMPLES) begin
                    vec_samples[vec_cnt] = i_sample;
                    vec_cnt++;
                    vec_sum += i_sample;
                    if (i_sample < vec_min) vec_min = i_sample;
                    if (i_sample > vec_max) vec_max = i_sample;
                end else begin
                    vec_drop = 1'b1;
                end
                if (i_last) begin
                    if (vec_cnt > 0) quantize_vector();
                    clear_vector();
                end
            end
            if (pop && !empty) begin
                o_results++;
                if (quant_queue.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result offset=%0d mean=%0d step=%0d",
                             $time, o_offset, o_mean_value, o_step_size);
                end else begin
                    want = quant_queue.pop_front();
                    if (o_offset !== want.offset) begin
                        o_errors++;
                        $display("%0t: offset expected %0d actual %0d",
                                 $time, want.offset, o_offset);
                    end
                    if (o_mean_value !== want.mean_value) begin
                        o_errors++;
                        $display("%0t: mean_value expected %0d actual %0d",
                                 $time, want.mean_value, o_mean_value);
                    end
                    if (o_step_size !== want.step_size) begin
                        o_errors++;
                        $display("%0t: step_size expected %0d actual %0d",
                                 $time, want.step_size, o_step_size);
                    end
                    if (o_end_of_vector !== want.end_of_vector) begin
                        o_errors++;
                        $display("%0t: end_of_vector expected %0b actual %0b",
                                 $time, want.end_of_vector, o_end_of_vector);
                    end
                    if (o_overflowed !== want.overflowed) begin
                        o_errors++;
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $time, want.overflowed, o_overflowed);
                    end
                end
            end
            o_pending = quant_queue.size();
        end
    end
endmodule
`default_nettype wire

// ===== verif/mean_centered_vector_quantizer_test.sv =====
`default_nettype none
module mean_centered_vector_quantizer_test;
    import mcvq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic signed [DATA_W-1:0] i_sample;
    logic                     i_last;
    logic                     empty;
    logic                     pop;
    logic signed [OFF_W-1:0]  o_offset;
    logic signed [MEAN_W-1:0] o_mean_value;
    logic [STEP_W-1:0]        o_step_size;
    logic                     o_end_of_vector;
    logic                     o_overflowed;

    int errors, pending, vectors, results;
    int tx_idle_pct, rx_idle_pct;
    int sent;
    bit rx_hold;

    mean_centered_vector_quantizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_sample(i_sample), .i_last(i_last), .empty(empty), .pop(pop),
        .o_offset(o_offset), .o_mean_value(o_mean_value), .o_step_size(o_step_size),
        .o_end_of_vector(o_end_of_vector), .o_overflowed(o_overflowed)
    );

    mcvq_result_checker i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_sample(i_sample), .i_last(i_last), .empty(empty), .pop(pop),
        .o_offset(o_offset), .o_mean_value(o_mean_value), .o_step_size(o_step_size),
        .o_end_of_vector(o_end_of_vector), .o_overflowed(o_overflowed),
        .o_errors(errors), .o_pending(pending), .o_vectors(vectors),
        .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one sample beat and hold it until taken.
    task automatic send_beat(input logic signed [DATA_W-1:0] s, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= s;
        i_last   <= lst;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    task automatic send_vector(input int len, input int base, input int spread);
        logic signed [DATA_W-1:0] s;
        for (int k = 0; k < len; k++) begin
            if (spread < 0) s = DATA_W'($urandom);
            else s = DATA_W'(base + int'($urandom_range(spread)));
            send_beat(s, k == len - 1);
        end
    endtask

    // Receiver: pops at random, or holds off while rx_hold is set.
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        push = 1'b0;
        i_sample = '0;
        i_last = 1'b0;
        i_rst_n = 1'b0;
        rx_hold = 1'b0;
        sent = 0;
        tx_idle_pct = 31;
        rx_idle_pct = 78;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single sample, equal samples, extremes, small random vector
        send_beat(16'sh7fff, 1'b1);
        send_beat(16'sh8000, 1'b1);
        send_beat(16'sh1234, 1'b0);
        send_beat(16'sh1234, 1'b0);
        send_beat(16'sh1234, 1'b1);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'shffff, 1'b1);
        send_vector(3, -2, 4);

        // hold the receiver off for a while, counted on its own, while a long
        // overflowing vector and another one keep coming
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        send_vector(MAX_SAMPLES_DEF + 2, 0, -1);
        send_vector(2, 100, 50);
        push <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);

        while (sent < 130) begin
            if (sent >= 105) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (sent >= 75) begin
                tx_idle_pct = 78;
                rx_idle_pct = 31;
            end
            case ($urandom_range(9))
                0:       send_vector($urandom_range(MAX_SAMPLES_DEF - 1, MAX_SAMPLES_DEF + 3),
                                     0, -1);
                1, 2:    send_vector($urandom_range(1, 6), $urandom_range(200) - 100, 3);
                3:       send_vector($urandom_range(1, 4), 500, 0);
                default: send_vector($urandom_range(1, 6), 0, -1);
            endcase
        end
        push <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Ran %0d sample beats over %0d vectors, %0d results checked,", sent,
                 vectors, results);
        $display("including overflow, equal-sample, extreme and back-pressure cases.");
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
